// ===== sv/wnss_pkg.sv =====
`default_nettype none

package wnss_pkg;

    // Table geometry and number formats.
    localparam int MAX_ENTRIES  = 1024;
    localparam int FEATURE_BITS = 16;
    localparam int NFEAT        = 6;
    localparam int NREG         = 6;
    localparam int WEIGHT_BITS  = 16;
    localparam int ADDR_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W        = 10;
    localparam int DIST_W       = 48;
    localparam int CFG_IDX_W    = 3;

    // Depth of the command queue between front and back; a power of two so
    // the pointers wrap on their own.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Weight reset values, register 0 in the low slot.
    localparam logic [NREG-1:0][WEIGHT_BITS-1:0] WEIGHT_RESET = {
        16'd4096, 16'd4096, 16'd4096, 16'd4096, 16'd41, 16'd4096
    };

    // Action codes of an input word.
    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    // Operations handed from the front to the back.
    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_APPEND = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_W_TEMP     = 3'd0,
        REG_W_SLACK    = 3'd1,
        REG_W_ACCEPT   = 3'd2,
        REG_W_CRIT     = 3'd3,
        REG_W_IMBAL    = 3'd4,
        REG_W_STALE    = 3'd5
    } t_reg_idx;

    typedef logic [FEATURE_BITS-1:0] t_feat;
    typedef t_feat [NFEAT-1:0] t_vec;

    typedef struct packed {
        logic [1:0]               action;
        logic signed [15:0]       temp_progress;
        logic signed [15:0]       worst_slack;
        logic signed [15:0]       acceptance_rate;
        logic signed [15:0]       crit_density;
        logic signed [15:0]       cost_imbalance;
        logic signed [15:0]       stale_moves;
    } t_in_word;

    typedef struct packed {
        logic                     found;
        logic [IDX_W-1:0]         nearest_index;
        logic [DIST_W-1:0]        best_distance;
        logic                     append_dropped;
    } t_out_word;

    // Classified command as it travels through the queue.
    typedef struct packed {
        t_op  op;
        t_vec feat;
    } t_cmd;

endpackage

`default_nettype wire

// ===== sv/wnss_front.sv =====
`default_nettype none

module wnss_front
    import wnss_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_word i_data,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_ready,
    output t_cmd          o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;

    // The holding register frees up whenever its word moves on.
    assign o_ready     = !r_valid || i_cmd_ready;
    assign take        = i_valid && o_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Classify the action and gather the features into one vector.
    always_comb begin
        n_cmd.feat[0] = i_data.temp_progress;
        n_cmd.feat[1] = i_data.worst_slack;
        n_cmd.feat[2] = i_data.acceptance_rate;
        n_cmd.feat[3] = i_data.crit_density;
        n_cmd.feat[4] = i_data.cost_imbalance;
        n_cmd.feat[5] = i_data.stale_moves;
        case (t_action'(i_data.action))
            ACT_CLEAR:  n_cmd.op = OP_CLEAR;
            ACT_APPEND: n_cmd.op = OP_APPEND;
            ACT_QUERY:  n_cmd.op = OP_QUERY;
            default:    n_cmd.op = OP_NOP;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_cmd_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/wnss_queue.sv =====
`default_nettype none

module wnss_queue
    import wnss_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_cmd i_push_cmd,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_cmd      o_pop_cmd
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_fill;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_fill != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_fill != '0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    // Command slots.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/wnss_back.sv =====
`default_nettype none

module wnss_back
    import wnss_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cmd_valid,
    output logic                        o_cmd_ready,
    input  wire t_cmd                   i_cmd,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output t_out_word                   o_data,
    input  wire logic                   i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [WEIGHT_BITS-1:0] i_cfg_data
);

    localparam int FB      = FEATURE_BITS;
    localparam int ABS_W   = FB + 1;
    localparam int SQ_W    = 2 * ABS_W;
    localparam int TERM_W  = SQ_W + WEIGHT_BITS;
    localparam int PAIR_W  = DIST_W + 1;
    localparam int TOT_W   = DIST_W + 3;
    localparam int NPAIR   = NFEAT / 2;
    localparam int PIPE_N  = 6;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // Control state.
    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [ADDR_W-1:0] r_scan_idx;
    logic [ADDR_W-1:0] n_scan_idx;
    logic              r_out_valid;
    logic              n_out_valid;
    t_out_word         r_out;
    t_out_word         n_out;
    logic [PIPE_N-1:0] r_v;
    logic              r_found;
    logic [NREG-1:0][WEIGHT_BITS-1:0] r_w;

    // Datapath registers.
    t_vec                          r_qry;
    t_vec                          r_mem [MAX_ENTRIES];
    t_vec                          r_rdata;
    logic [ADDR_W-1:0]             r_i [PIPE_N];
    logic [NFEAT-1:0][ABS_W-1:0]   r_abs;
    logic [NFEAT-1:0][SQ_W-1:0]    r_sq;
    logic [NFEAT-1:0][DIST_W-1:0]  r_term;
    logic [NPAIR-1:0][PAIR_W-1:0]  r_pair;
    logic [DIST_W-1:0]             r_dist;
    logic [DIST_W-1:0]             r_best;
    logic [ADDR_W-1:0]             r_best_idx;

    logic                          out_free;
    logic                          pop;
    logic                          issue;
    logic                          scan_last;
    logic                          query_start;
    logic                          mem_we;
    logic [NFEAT-1:0][ABS_W-1:0]   abs_d;
    logic [NFEAT-1:0][ABS_W-1:0]   diff;
    logic [NFEAT-1:0][SQ_W-1:0]    sq;
    logic [NFEAT-1:0][TERM_W-1:0]  prod;
    logic [NFEAT-1:0][DIST_W-1:0]  term;
    logic [TERM_W+DIST_W-1:0]      prod_wide [NFEAT];
    logic [NPAIR-1:0][PAIR_W-1:0]  pair;
    logic [TOT_W-1:0]              total;
    logic [DIST_W-1:0]             dist_sat;
    logic                          better;
    logic [ADDR_W+IDX_W-1:0]       idx_ext;

    assign out_free    = !r_out_valid || i_ready;
    assign pop         = (r_state == S_IDLE) && i_cmd_valid && out_free;
    assign o_cmd_ready = pop;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign issue       = (r_state == S_SCAN);
    assign scan_last   = (CNT_W'(r_scan_idx) + 1'b1) == r_count;
    assign query_start = pop && (i_cmd.op == OP_QUERY) && (r_count != '0);
    assign mem_we      = pop && (i_cmd.op == OP_APPEND)
                         && (r_count < CNT_W'(MAX_ENTRIES));
    assign better      = r_v[PIPE_N-1] && (!r_found || (r_dist < r_best));
    assign idx_ext     = {{IDX_W{1'b0}}, r_best_idx};

    // Command sequencer and result register.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_scan_idx  = r_scan_idx;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (pop) begin
                    n_out = '0;
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                        end
                        OP_APPEND: begin
                            if (mem_we) begin
                                n_count = r_count + 1'b1;
                            end else begin
                                n_out.append_dropped = 1'b1;
                            end
                            n_out_valid = 1'b1;
                        end
                        OP_QUERY: begin
                            if (query_start) begin
                                n_scan_idx = '0;
                                n_state    = S_SCAN;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_scan_idx = r_scan_idx + 1'b1;
                if (scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_v == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.found          = r_found;
                    n_out.nearest_index  = idx_ext[IDX_W-1:0];
                    n_out.best_distance  = r_best;
                    n_out.append_dropped = 1'b0;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan_idx  <= '0;
            r_out_valid <= 1'b0;
            r_v         <= '0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan_idx  <= n_scan_idx;
            r_out_valid <= n_out_valid;
            r_v         <= {r_v[PIPE_N-2:0], issue};
            if (query_start) begin
                r_found <= 1'b0;
            end else if (better) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Weight registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= WEIGHT_RESET;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_W_TEMP:   r_w[0] <= i_cfg_data;
                REG_W_SLACK:  r_w[1] <= i_cfg_data;
                REG_W_ACCEPT: r_w[2] <= i_cfg_data;
                REG_W_CRIT:   r_w[3] <= i_cfg_data;
                REG_W_IMBAL:  r_w[4] <= i_cfg_data;
                REG_W_STALE:  r_w[5] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Feature memory: one write port for appends, one read port for the scan.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_cmd.feat;
        end
        r_rdata <= r_mem[r_scan_idx];
    end

    // Per-feature distance arithmetic, one operation per stage.
    always_comb begin
        for (int f = 0; f < NFEAT; f++) begin
            diff[f]  = {r_qry[f][FB-1], r_qry[f]} - {r_rdata[f][FB-1], r_rdata[f]};
            abs_d[f] = diff[f][ABS_W-1] ? (~diff[f] + 1'b1) : diff[f];
            sq[f]    = r_abs[f] * r_abs[f];
            prod[f]  = r_sq[f] * r_w[f];
            prod_wide[f] = {{DIST_W{1'b0}}, prod[f]};
            if (prod_wide[f] > {{TERM_W{1'b0}}, DIST_MAX}) begin
                term[f] = DIST_MAX;
            end else begin
                term[f] = prod_wide[f][DIST_W-1:0];
            end
        end
        for (int k = 0; k < NPAIR; k++) begin
            pair[k] = PAIR_W'(r_term[2*k]) + PAIR_W'(r_term[2*k+1]);
        end
        total = TOT_W'(r_pair[0]) + TOT_W'(r_pair[1]) + TOT_W'(r_pair[2]);
        if (total > TOT_W'(DIST_MAX)) begin
            dist_sat = DIST_MAX;
        end else begin
            dist_sat = total[DIST_W-1:0];
        end
    end

    // Distance pipeline and running minimum; the index rides along.
    always_ff @(posedge i_clk) begin
        if (query_start) begin
            r_qry <= i_cmd.feat;
        end
        r_i[0] <= r_scan_idx;
        for (int s = 1; s < PIPE_N; s++) begin
            r_i[s] <= r_i[s-1];
        end
        r_abs  <= abs_d;
        r_sq   <= sq;
        r_term <= term;
        r_pair <= pair;
        r_dist <= dist_sat;
        if (better) begin
            r_best     <= r_dist;
            r_best_idx <= r_i[PIPE_N-1];
        end
    end

endmodule

`default_nettype wire

// ===== sv/weighted_nearest_state_search_core.sv =====
`default_nettype none

// Weighted nearest stored state search. Each input word clears the table,
// appends its six-feature vector as the next entry, or queries the table for
// the entry with the smallest weighted squared distance (earliest entry wins a
// tie); every word yields exactly one result word. A front stage classifies
// words into a two-deep command queue, so input keeps flowing while the back
// end works. Clear, append and unused codes complete without a scan; a query
// is settled by the scan, which reads one stored entry per cycle through the
// single read port of the feature memory and feeds a six-stage distance
// pipeline. No clearing pass follows reset: the entry count alone marks which
// entries are valid. Weights may be written only while no word is in flight.
module weighted_nearest_state_search_core
    import wnss_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire t_in_word               i_data,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output t_out_word                   o_data,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [WEIGHT_BITS-1:0] i_cfg_data
);

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    // Weight writes are always taken.
    assign o_cfg_ready = 1'b1;

    wnss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    wnss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    wnss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

`default_nettype wire
